[rtl/core/tms_pkg.sv]
package tms_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int IdxWidth  = 4;
   localparam int Elements  = 16;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int AccWidth  = ProdWidth - FracBits + 2;

   localparam logic [DataWidth-1:0] QOne = DataWidth'(1) << FracBits;

   typedef enum logic [2:0] {
      OP_IDENTITY = 3'd0,
      OP_LOAD     = 3'd1,
      OP_STAGE    = 3'd2,
      OP_PUSH     = 3'd3,
      OP_POP      = 3'd4,
      OP_READ     = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic logic [DataWidth-1:0] identity_word(input logic [IdxWidth-1:0] idx);
      return (idx[1:0] == idx[3:2]) ? QOne : '0;
   endfunction

endpackage

[rtl/core/tms_ram.sv]
module tms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tms_mac.sv]
module tms_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  tms_pkg::mac_ctl_type          ctl,
   input  logic signed [tms_pkg::DataWidth-1:0] a,
   input  logic signed [tms_pkg::DataWidth-1:0] b,
   output logic                          done,
   output logic [tms_pkg::DataWidth-1:0] result
);

   localparam int AW = tms_pkg::AccWidth;
   localparam int DW = tms_pkg::DataWidth;

   logic signed [tms_pkg::ProdWidth-1:0] prod_ff;
   tms_pkg::mac_ctl_type                 ctl_ff;
   logic signed [AW-1:0]                 acc_ff;
   logic signed [AW-1:0]                 term;
   logic signed [AW-1:0]                 sum_in;

   localparam logic signed [AW-1:0] MaxVal = AW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [AW-1:0] MinVal = -MaxVal - AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= a * b;
      if (ctl_ff.valid) begin
         acc_ff <= sum_in;
      end
   end

   // floor shift of the product, then accumulate exactly
   always_comb begin
      term   = AW'(prod_ff >>> tms_pkg::FracBits);
      sum_in = (ctl_ff.first ? '0 : acc_ff) + term;
   end

   always_comb begin
      if (sum_in > MaxVal) begin
         result = MaxVal[DW-1:0];
      end else if (sum_in < MinVal) begin
         result = MinVal[DW-1:0];
      end else begin
         result = sum_in[DW-1:0];
      end
   end

   assign done = ctl_ff.valid && ctl_ff.last;

endmodule

[rtl/core/transform_matrix_stack.sv]
// Flow: read, load, pop and stage (index 0-14) go from start through S_RD to S_RSP;
// identity adds S_IDENT, push S_COPY (not when the stack is full), stage 15 S_FETCH, S_MAC.
// One item at a time: busy stays high until the result strobe has been shown.
// The 64 multiply-accumulates run on one shared multiplier; push copies 16 words over
// the single matrix memory port pair. After reset, level 0 is set to identity
// with busy high. The receiver cannot stall the result.
module transform_matrix_stack #(
   parameter int STACK_LEVELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_element_index,
   input  logic signed [31:0] req_element_value,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_top_value
);

   localparam int LW    = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
   localparam int DEPTH = STACK_LEVELS * tms_pkg::Elements;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = tms_pkg::DataWidth;
   localparam int IW    = tms_pkg::IdxWidth;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_IDENT, S_FETCH, S_MAC, S_COPY, S_RD, S_RSP
   } state_type;

   state_type            state_ff;
   logic [6:0]           cnt_ff;
   logic [LW-1:0]        lvl_ff;
   logic [IW-1:0]        idx_ff;
   logic [1:0]           status_ff;
   logic [IW-1:0]        wb_idx_ff;
   logic [DW-1:0]        tile_ff    [tms_pkg::Elements];
   logic [DW-1:0]        operand_ff [tms_pkg::Elements];

   logic                 accept;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [DW-1:0]        ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [DW-1:0]        ram_rdata;
   logic [IW-1:0]        cnt_prev;
   logic [LW-1:0]        lvl_up;
   tms_pkg::mac_ctl_type mac_ctl;
   logic                 mac_done;
   logic [DW-1:0]        mac_result;
   logic [1:0]           mac_c, mac_r, mac_k;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign cnt_prev = IW'(cnt_ff[IW-1:0] - 1'b1);
   assign lvl_up   = LW'(lvl_ff + 1'b1);
   assign mac_c    = cnt_ff[5:4];
   assign mac_r    = cnt_ff[3:2];
   assign mac_k    = cnt_ff[1:0];

   always_comb begin
      mac_ctl.valid = (state_ff == S_MAC) && !cnt_ff[6];
      mac_ctl.first = (mac_k == 2'd0);
      mac_ctl.last  = (mac_k == 2'd3);
   end

   tms_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a      (tile_ff[{mac_k, mac_r}]),
      .b      (operand_ff[{mac_c, mac_k}]),
      .done   (mac_done),
      .result (mac_result)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = AW'({lvl_ff, cnt_ff[IW-1:0]});
      ram_wdata = tms_pkg::identity_word(cnt_ff[IW-1:0]);
      priority if (state_ff == S_INIT || state_ff == S_IDENT) begin
         ram_we = 1'b1;
      end else if (accept && req_opcode == tms_pkg::OP_LOAD) begin
         ram_we    = 1'b1;
         ram_waddr = AW'({lvl_ff, req_element_index});
         ram_wdata = req_element_value;
      end else if (state_ff == S_COPY && cnt_ff != '0) begin
         ram_we    = 1'b1;
         ram_waddr = AW'({lvl_up, cnt_prev});
         ram_wdata = ram_rdata;
      end else if (state_ff == S_MAC && mac_done) begin
         ram_we    = 1'b1;
         ram_waddr = AW'({lvl_ff, wb_idx_ff});
         ram_wdata = mac_result;
      end else begin
         ram_we = 1'b0;
      end
   end

   always_comb begin
      if (state_ff == S_FETCH || state_ff == S_COPY) begin
         ram_raddr = AW'({lvl_ff, cnt_ff[IW-1:0]});
      end else begin
         ram_raddr = AW'({lvl_ff, idx_ff});
      end
   end

   tms_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         cnt_ff    <= '0;
         lvl_ff    <= '0;
         status_ff <= tms_pkg::ST_OK;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               cnt_ff <= 7'(cnt_ff + 1'b1);
               if (cnt_ff[IW-1:0] == IW'(tms_pkg::Elements - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  idx_ff    <= req_element_index;
                  status_ff <= tms_pkg::ST_OK;
                  cnt_ff    <= '0;
                  state_ff  <= S_RD;
                  unique case (req_opcode)
                     tms_pkg::OP_IDENTITY: state_ff <= S_IDENT;
                     tms_pkg::OP_STAGE: begin
                        operand_ff[req_element_index] <= req_element_value;
                        if (req_element_index == IW'(tms_pkg::Elements - 1)) begin
                           state_ff <= S_FETCH;
                        end
                     end
                     tms_pkg::OP_PUSH: begin
                        if (lvl_ff == LW'(STACK_LEVELS - 1)) begin
                           status_ff <= tms_pkg::ST_OVERFLOW;
                        end else begin
                           state_ff <= S_COPY;
                        end
                     end
                     tms_pkg::OP_POP: begin
                        if (lvl_ff == '0) begin
                           status_ff <= tms_pkg::ST_UNDERFLOW;
                        end else begin
                           lvl_ff <= LW'(lvl_ff - 1'b1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_IDENT: begin
               cnt_ff <= 7'(cnt_ff + 1'b1);
               if (cnt_ff[IW-1:0] == IW'(tms_pkg::Elements - 1)) begin
                  state_ff <= S_RD;
               end
            end
            S_FETCH: begin
               // read data arrives in the cycle after its address
               if (cnt_ff != '0) begin
                  tile_ff[cnt_prev] <= ram_rdata;
               end
               cnt_ff <= 7'(cnt_ff + 1'b1);
               if (cnt_ff[4]) begin
                  cnt_ff   <= '0;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               wb_idx_ff <= {mac_c, mac_r};
               cnt_ff    <= 7'(cnt_ff + 1'b1);
               if (cnt_ff[6]) begin
                  state_ff <= S_RD;
               end
            end
            S_COPY: begin
               cnt_ff <= 7'(cnt_ff + 1'b1);
               if (cnt_ff[4]) begin
                  lvl_ff   <= lvl_up;
                  state_ff <= S_RD;
               end
            end
            S_RD:  state_ff <= S_RSP;
            S_RSP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe    = (state_ff == S_RSP);
   assign rsp_status    = status_ff;
   assign rsp_top_value = ram_rdata;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting an item");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(STACK_LEVELS - 1))
      else $error("stack level out of range");

   a_mac_in_mult: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == S_MAC)
      else $error("accumulator finished outside multiply");

endmodule
